### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// Widths, types and register codes for the triangle/box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

  localparam int COORD_BITS = 24;
  localparam int EXT_BITS   = 23;

  localparam int VERT_BITS  = COORD_BITS + 1;
  localparam int EDGE_BITS  = COORD_BITS + 2;

  // edge x box-axis tests
  localparam int EPROD_BITS = VERT_BITS + EDGE_BITS;
  localparam int EPROJ_BITS = EPROD_BITS + 1;
  localparam int ERPRD_BITS = EXT_BITS + EDGE_BITS;
  localparam int ERAD_BITS  = ERPRD_BITS + 1;
  localparam int ECMP_BITS  = EPROJ_BITS + 1;

  // triangle normal test
  localparam int NPROD_BITS = 2 * EDGE_BITS;
  localparam int NORM_BITS  = NPROD_BITS + 1;
  localparam int NABS_BITS  = NORM_BITS - 1;
  localparam int SPLIT      = EDGE_BITS;
  localparam int NHI_BITS   = NORM_BITS - SPLIT;
  localparam int AHI_BITS   = NABS_BITS - SPLIT;
  localparam int PLO_BITS   = VERT_BITS + SPLIT + 1;
  localparam int PHI_BITS   = VERT_BITS + NHI_BITS;
  localparam int RLO_BITS   = EXT_BITS + SPLIT;
  localparam int RHI_BITS   = EXT_BITS + AHI_BITS;
  localparam int DOT_BITS   = VERT_BITS + NORM_BITS + 2;

  localparam int IDX_BITS   = 2;
  localparam logic [EXT_BITS-1:0] EXT_RESET = EXT_BITS'(128);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [VERT_BITS-1:0]  vert_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic [EXT_BITS-1:0]          ext_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

`default_nettype wire

### design/tbo_edge_axis.sv
// ----------------------------------------------------------------------------
// tbo_edge_axis
// One edge x box-axis separation test, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_edge_axis (
  input  logic               clk,
  input  tbo_pkg::stage_en_t en,
  input  tbo_pkg::vert_t     on_i,
  input  tbo_pkg::vert_t     on_j,
  input  tbo_pkg::vert_t     off_i,
  input  tbo_pkg::vert_t     off_j,
  input  tbo_pkg::edge_t     e_i,
  input  tbo_pkg::edge_t     e_j,
  input  tbo_pkg::ext_t      h_i,
  input  tbo_pkg::ext_t      h_j,
  output logic               sep
);
  import tbo_pkg::*;

  logic [EDGE_BITS-1:0] abs_i, abs_j;
  logic signed [EPROD_BITS-1:0] m_on_a, m_on_b, m_off_a, m_off_b;
  logic [ERPRD_BITS-1:0] r_a, r_b;
  logic signed [EPROJ_BITS-1:0] p_on, p_off;
  logic [ERAD_BITS-1:0] rad;
  logic signed [ECMP_BITS-1:0] lo, hi, rs;

  assign abs_i = e_i[EDGE_BITS-1] ? EDGE_BITS'(-e_i) : EDGE_BITS'(e_i);
  assign abs_j = e_j[EDGE_BITS-1] ? EDGE_BITS'(-e_j) : EDGE_BITS'(e_j);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m_on_a  <= on_i * e_j;
      m_on_b  <= on_j * e_i;
      m_off_a <= off_i * e_j;
      m_off_b <= off_j * e_i;
      r_a     <= h_i * abs_j;
      r_b     <= h_j * abs_i;
    end
    if (en.s4) begin
      p_on  <= EPROJ_BITS'(m_on_a) - EPROJ_BITS'(m_on_b);
      p_off <= EPROJ_BITS'(m_off_a) - EPROJ_BITS'(m_off_b);
      rad   <= ERAD_BITS'(r_a) + ERAD_BITS'(r_b);
    end
    if (en.s5) begin
      sep <= (rs < lo) || (hi < -rs);
    end
  end

  // zero axis gives zero projection and radius, so it never separates
  always_comb begin
    rs = $signed(ECMP_BITS'(rad));
    if (p_on < p_off) begin
      lo = ECMP_BITS'(p_on);
      hi = ECMP_BITS'(p_off);
    end else begin
      lo = ECMP_BITS'(p_off);
      hi = ECMP_BITS'(p_on);
    end
  end

endmodule

`default_nettype wire

### design/triangle_box_overlap_test.sv
// Seven register stages with valid bits; an input transfer enters stage 1
// and leaves stage 7 as out_valid. Throughput: one triangle per cycle
// unless out_ready stalls; each stage advances when empty or the next moves.
// Reset: pipeline empties, half extents return to 0.5 (128 raw).
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis overlap test of a triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module triangle_box_overlap_test (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tbo_pkg::coord_t vertex_a_x,
  input  tbo_pkg::coord_t vertex_a_y,
  input  tbo_pkg::coord_t vertex_a_z,
  input  tbo_pkg::coord_t vertex_b_x,
  input  tbo_pkg::coord_t vertex_b_y,
  input  tbo_pkg::coord_t vertex_b_z,
  input  tbo_pkg::coord_t vertex_c_x,
  input  tbo_pkg::coord_t vertex_c_y,
  input  tbo_pkg::coord_t vertex_c_z,
  input  tbo_pkg::coord_t center_x,
  input  tbo_pkg::coord_t center_y,
  input  tbo_pkg::coord_t center_z,
  output logic out_valid,
  input  logic out_ready,
  output logic overlaps,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tbo_pkg::IDX_BITS-1:0] cfg_index,
  input  tbo_pkg::ext_t cfg_data
);
  import tbo_pkg::*;

  ext_t  h [3];
  coord_t pin [3][3];
  coord_t pc [3];

  logic [7:1] vld, adv;

  vert_t v1 [3][3];
  vert_t v2 [3][3];
  edge_t e2 [3][3];
  logic  bs2, bs3, bs4, bs5;
  logic  [2:0] box_sep;
  logic signed [NPROD_BITS-1:0] np3 [3][2];
  vert_t v03 [3];
  vert_t v04 [3];
  logic signed [NORM_BITS-1:0] n4 [3];
  logic signed [PLO_BITS-1:0] plo5 [3];
  logic signed [PHI_BITS-1:0] phi5 [3];
  logic [RLO_BITS-1:0] rlo5 [3];
  logic [RHI_BITS-1:0] rhi5 [3];
  logic [SPLIT-1:0] nlo [3];
  logic signed [NHI_BITS-1:0] nhi [3];
  logic [NABS_BITS-1:0] nabs [3];
  logic signed [DOT_BITS-1:0] dot_next, dot6, rad6;
  logic [DOT_BITS-1:0] rad_next;
  logic os6, ov7;
  logic [8:0] esep;
  stage_en_t en;

  assign pin[0][0] = vertex_a_x;
  assign pin[0][1] = vertex_a_y;
  assign pin[0][2] = vertex_a_z;
  assign pin[1][0] = vertex_b_x;
  assign pin[1][1] = vertex_b_y;
  assign pin[1][2] = vertex_b_z;
  assign pin[2][0] = vertex_c_x;
  assign pin[2][1] = vertex_c_y;
  assign pin[2][2] = vertex_c_z;
  assign pc[0] = center_x;
  assign pc[1] = center_y;
  assign pc[2] = center_z;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      h[0] <= EXT_RESET;
      h[1] <= EXT_RESET;
      h[2] <= EXT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_X: h[0] <= cfg_data;
        REG_HALF_Y: h[1] <= cfg_data;
        REG_HALF_Z: h[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage control
  always_comb begin
    adv[7] = !vld[7] || out_ready;
    for (int i = 6; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[7];
  assign overlaps  = ov7;
  assign en = '{s3: adv[3], s4: adv[4], s5: adv[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      for (int i = 2; i <= 7; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // box axes: vertex range against [-h, h]
  always_comb begin
    vert_t mn, mx, hs;
    for (int d = 0; d < 3; d++) begin
      mn = v1[0][d];
      mx = v1[0][d];
      for (int k = 1; k < 3; k++) begin
        if (v1[k][d] < mn) mn = v1[k][d];
        if (v1[k][d] > mx) mx = v1[k][d];
      end
      hs = $signed(VERT_BITS'(h[d]));
      box_sep[d] = (hs < mn) || (mx < -hs);
    end
  end

  // normal split into partial products
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      nlo[d]  = n4[d][SPLIT-1:0];
      nhi[d]  = n4[d][NORM_BITS-1:SPLIT];
      nabs[d] = n4[d][NORM_BITS-1] ? NABS_BITS'(-n4[d]) : NABS_BITS'(n4[d]);
    end
  end

  always_comb begin
    dot_next = '0;
    rad_next = '0;
    for (int d = 0; d < 3; d++) begin
      dot_next = dot_next + (DOT_BITS'(phi5[d]) <<< SPLIT) + DOT_BITS'(plo5[d]);
      rad_next = rad_next + (DOT_BITS'(rhi5[d]) << SPLIT) + DOT_BITS'(rlo5[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int d = 0; d < 3; d++) begin
          v1[k][d] <= VERT_BITS'(pin[k][d]) - VERT_BITS'(pc[d]);
        end
      end
    end
    if (adv[2]) begin
      v2  <= v1;
      bs2 <= |box_sep;
      for (int k = 0; k < 3; k++) begin
        for (int d = 0; d < 3; d++) begin
          e2[k][d] <= EDGE_BITS'(v1[(k+1)%3][d]) - EDGE_BITS'(v1[k][d]);
        end
      end
    end
    if (adv[3]) begin
      bs3 <= bs2;
      for (int d = 0; d < 3; d++) begin
        v03[d]    <= v2[0][d];
        np3[d][0] <= e2[0][(d+1)%3] * e2[1][(d+2)%3];
        np3[d][1] <= e2[0][(d+2)%3] * e2[1][(d+1)%3];
      end
    end
    if (adv[4]) begin
      bs4 <= bs3;
      v04 <= v03;
      for (int d = 0; d < 3; d++) begin
        n4[d] <= NORM_BITS'(np3[d][0]) - NORM_BITS'(np3[d][1]);
      end
    end
    if (adv[5]) begin
      bs5 <= bs4;
      for (int d = 0; d < 3; d++) begin
        plo5[d] <= v04[d] * $signed({1'b0, nlo[d]});
        phi5[d] <= v04[d] * nhi[d];
        rlo5[d] <= h[d] * nabs[d][SPLIT-1:0];
        rhi5[d] <= h[d] * nabs[d][NABS_BITS-1:SPLIT];
      end
    end
    if (adv[6]) begin
      os6  <= bs5 || (|esep);
      dot6 <= dot_next;
      rad6 <= $signed(rad_next);
    end
    if (adv[7]) begin
      ov7 <= !(os6 || (rad6 < dot6) || (dot6 < -rad6));
    end
  end

  // edge x box-axis tests, one for each edge and box axis
  for (genvar k = 0; k < 3; k++) begin : g_edge
    for (genvar d = 0; d < 3; d++) begin : g_axis
      tbo_edge_axis u_axis (
        .clk   (clk),
        .en    (en),
        .on_i  (v2[k][(d+1)%3]),
        .on_j  (v2[k][(d+2)%3]),
        .off_i (v2[(k+2)%3][(d+1)%3]),
        .off_j (v2[(k+2)%3][(d+2)%3]),
        .e_i   (e2[k][(d+1)%3]),
        .e_j   (e2[k][(d+2)%3]),
        .h_i   (h[(d+1)%3]),
        .h_j   (h[(d+2)%3]),
        .sep   (esep[k*3+d])
      );
    end
  end

  `ASSERT_SAME(a_empty_head_ready, !vld[1], in_ready)
  `ASSERT_NEXT(a_transfer_enters, in_valid && in_ready, vld[1])
  `ASSERT_NEXT(a_stall_holds_tail, vld[7] && !out_ready, vld[7] && $stable(ov7))

endmodule

`default_nettype wire
